FILE: sv/btrl_pkg.sv
package btrl_pkg;

    // Default sizes of the route table
    localparam int ADDR_BITS_DEF    = 128;
    localparam int NODE_COUNT_DEF   = 4096;
    localparam int HOST_ID_BITS_DEF = 16;

    // Fixed field widths of the request and result words
    localparam int REQ_TYPE_W   = 2;
    localparam int ADDR_HALF_W  = 64;
    localparam int BIT_COUNT_W  = 8;
    localparam int HOST_IN_W    = 16;
    localparam int STATUS_W     = 2;
    localparam int ROUTE_HOST_W = 15;

    // Request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOROUTE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0]  req_type;
        logic [ADDR_HALF_W-1:0] addr_high;
        logic [ADDR_HALF_W-1:0] addr_low;
        logic [BIT_COUNT_W-1:0] bit_count;
        logic [HOST_IN_W-1:0]   host_id;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [ROUTE_HOST_W-1:0] route_host;
    } res_t;

endpackage

FILE: sv/btrl_engine.sv
module btrl_engine #(
    parameter int ADDR_BITS    = btrl_pkg::ADDR_BITS_DEF,
    parameter int NODE_COUNT   = btrl_pkg::NODE_COUNT_DEF,
    parameter int HOST_ID_BITS = btrl_pkg::HOST_ID_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  btrl_pkg::req_t  req,
    input  logic            req_valid,
    output logic            req_ready,
    output btrl_pkg::res_t  res,
    output logic            res_valid,
    input  logic            res_ready
);

    localparam int IDX_W  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CNT_W  = $clog2(NODE_COUNT + 1);
    localparam int LEN_W  = $clog2(ADDR_BITS + 1);
    localparam int SUM_W  = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
    localparam int HV_W   = HOST_ID_BITS - 1;
    localparam int HX_W   = (HV_W > btrl_pkg::HOST_IN_W) ? HV_W : btrl_pkg::HOST_IN_W;
    localparam int RT_W   = (HV_W > btrl_pkg::ROUTE_HOST_W) ? HV_W : btrl_pkg::ROUTE_HOST_W;
    localparam int FULL_W = 2 * btrl_pkg::ADDR_HALF_W;

    typedef struct packed {
        logic [IDX_W-1:0] child1;
        logic [IDX_W-1:0] child0;
        logic             valid;
        logic [HV_W-1:0]  host;
    } node_t;

    localparam node_t NODE_EMPTY = '{child1: '0, child0: '0, valid: 1'b0, host: '0};

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_CHECK,
        S_ALLOC,
        S_FIN,
        S_DONE
    } state_t;

    // Node pool; index 0 is the root, which lives in flip-flops
    node_t mem [NODE_COUNT];
    node_t rd_data_reg;

    state_t                state_reg, state_next;
    node_t                 root_reg, root_next;
    logic [CNT_W-1:0]      used_reg, used_next;
    logic                  src_mem_reg, src_mem_next;
    logic                  found_reg, found_next;
    logic                  is_add_reg, is_add_next;
    btrl_pkg::res_t        res_reg, res_next;

    logic [ADDR_BITS-1:0]  sr_reg, sr_next;
    logic [LEN_W-1:0]      rem_reg, rem_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    node_t                 ent_reg, ent_next;
    logic [HV_W-1:0]       best_reg, best_next;
    logic [btrl_pkg::HOST_IN_W-1:0] host_reg, host_next;

    logic                  mem_we;
    logic                  mem_re;
    logic [IDX_W-1:0]      mem_raddr;
    node_t                 wentry;
    node_t                 ent;
    logic                  bit_cur;
    logic [IDX_W-1:0]      nx;
    logic                  found_w;
    logic [HV_W-1:0]       best_w;
    logic [RT_W-1:0]       best_wide;
    logic [HX_W:0]         host_wide;
    logic                  hneg;
    logic [HV_W-1:0]       hval;
    logic [SUM_W-1:0]      need_sum;
    logic [FULL_W-1:0]     addr_full;

    // Current node entry: root regs at first level, else last memory read
    assign ent       = src_mem_reg ? rd_data_reg : ent_reg;
    assign bit_cur   = sr_reg[ADDR_BITS-1];
    assign nx        = bit_cur ? ent.child1 : ent.child0;
    assign found_w   = found_reg | ent.valid;
    assign best_w    = ent.valid ? ent.host : best_reg;
    assign best_wide = RT_W'(best_w);

    // Host id sign at bit HOST_ID_BITS-1, value in the bits below it
    assign host_wide = (HX_W + 1)'(host_reg);
    assign hneg      = host_wide[HV_W];
    assign hval      = host_wide[HV_W-1:0];

    assign need_sum  = SUM_W'(used_reg) + SUM_W'(rem_reg);
    assign addr_full = {req.addr_high, req.addr_low};

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next   = state_reg;
        root_next    = root_reg;
        used_next    = used_reg;
        src_mem_next = src_mem_reg;
        found_next   = found_reg;
        is_add_next  = is_add_reg;
        res_next     = res_reg;
        sr_next      = sr_reg;
        rem_next     = rem_reg;
        cur_next     = cur_reg;
        ent_next     = ent_reg;
        best_next    = best_reg;
        host_next    = host_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_raddr    = nx;
        wentry       = ent_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_next.status     = btrl_pkg::ST_OK;
                    res_next.route_host = '0;
                    unique case (req.req_type)
                        btrl_pkg::REQ_ADD, btrl_pkg::REQ_LOOKUP:
                        begin
                            // Load the walk from the root
                            sr_next      = addr_full[FULL_W-1 -: ADDR_BITS];
                            rem_next     = (req.bit_count > 8'(ADDR_BITS))
                                           ? LEN_W'(ADDR_BITS) : LEN_W'(req.bit_count);
                            cur_next     = '0;
                            ent_next     = root_reg;
                            src_mem_next = 1'b0;
                            found_next   = 1'b0;
                            best_next    = '0;
                            host_next    = req.host_id;
                            is_add_next  = (req.req_type == btrl_pkg::REQ_ADD);
                            state_next   = S_WALK;
                        end
                        btrl_pkg::REQ_CLEAR:
                        begin
                            root_next  = NODE_EMPTY;
                            used_next  = CNT_W'(1);
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                found_next = found_w;
                best_next  = best_w;
                if ((rem_reg == '0) || (nx == '0))
                begin
                    if (is_add_reg)
                    begin
                        // Hold the end node for the allocation pass
                        ent_next     = ent;
                        src_mem_next = 1'b0;
                        state_next   = S_CHECK;
                    end
                    else
                    begin
                        res_next.status     = found_w ? btrl_pkg::ST_OK : btrl_pkg::ST_NOROUTE;
                        res_next.route_host = found_w ? best_wide[btrl_pkg::ROUTE_HOST_W-1:0]
                                                      : '0;
                        state_next          = S_DONE;
                    end
                end
                else
                begin
                    // Advance one level: fetch the child, drop the used bit
                    mem_re       = 1'b1;
                    cur_next     = nx;
                    sr_next      = sr_reg << 1;
                    rem_next     = rem_reg - LEN_W'(1);
                    src_mem_next = 1'b1;
                end
            end

            S_CHECK:
            begin
                priority if (need_sum > SUM_W'(NODE_COUNT))
                begin
                    res_next.status = btrl_pkg::ST_FULL;
                    state_next      = S_DONE;
                end
                else if (rem_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_ALLOC;
                end
            end

            S_ALLOC:
            begin
                // Link a fresh node below the current one and step into it
                if (bit_cur)
                begin
                    wentry.child1 = used_reg[IDX_W-1:0];
                end
                else
                begin
                    wentry.child0 = used_reg[IDX_W-1:0];
                end
                if (cur_reg == '0)
                begin
                    root_next = wentry;
                end
                else
                begin
                    mem_we = 1'b1;
                end
                cur_next  = used_reg[IDX_W-1:0];
                ent_next  = NODE_EMPTY;
                used_next = used_reg + CNT_W'(1);
                sr_next   = sr_reg << 1;
                rem_next  = rem_reg - LEN_W'(1);
                if (rem_reg == LEN_W'(1))
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                // Store or remove the route at the final node
                wentry.valid = ~hneg;
                wentry.host  = hneg ? '0 : hval;
                if (cur_reg == '0)
                begin
                    root_next = wentry;
                end
                else
                begin
                    mem_we = 1'b1;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Node memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cur_reg] <= wentry;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Control state and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            root_reg    <= NODE_EMPTY;
            used_reg    <= CNT_W'(1);
            src_mem_reg <= 1'b0;
            found_reg   <= 1'b0;
            is_add_reg  <= 1'b0;
            res_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            root_reg    <= root_next;
            used_reg    <= used_next;
            src_mem_reg <= src_mem_next;
            found_reg   <= found_next;
            is_add_reg  <= is_add_next;
            res_reg     <= res_next;
        end
    end

    // Walk payload
    always_ff @(posedge clk)
    begin
        sr_reg   <= sr_next;
        rem_reg  <= rem_next;
        cur_reg  <= cur_next;
        ent_reg  <= ent_next;
        best_reg <= best_next;
        host_reg <= host_next;
    end

endmodule

FILE: sv/binary_trie_route_lookup_top.sv
// Longest-prefix-match route table kept as a binary trie in a node pool.
// Input stream (s_axis): one request word per handshake; tuser carries the
// request kind (add, lookup, clear), tdata the address, prefix length and
// host id. Output stream (m_axis): one result word per request; tuser holds
// the status, tdata the host id of the longest matching prefix.
// The address is walked one bit per cycle, MSB first; each level costs one
// node-memory read. With L = min(bit_count, ADDR_BITS), a lookup walks at
// most L levels (fewer when the path ends early); an add walks, checks,
// allocates and stores (less when full); a clear resets the root.
// The result word shows on m_axis in the cycle s_axis_tready returns.
// A new request is accepted once the previous one has moved into the output
// register; a result waiting there does not block the next request, but a
// second result waits inside until m_axis_tready drains the first.
// Reset leaves an empty table with only the root allocated; the pool needs
// no clearing pass, since nodes are initialized as they are allocated.
module binary_trie_route_lookup_top #(
    parameter int ADDR_BITS    = btrl_pkg::ADDR_BITS_DEF,
    parameter int NODE_COUNT   = btrl_pkg::NODE_COUNT_DEF,
    parameter int HOST_ID_BITS = btrl_pkg::HOST_ID_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [151:0] s_axis_tdata,  // addr_high, addr_low, bit_count, host_id
    input  logic [1:0]   s_axis_tuser,  // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [15:0]  m_axis_tdata,  // route_host, one zero pad bit
    output logic [1:0]   m_axis_tuser   // status
);

    btrl_pkg::req_t req;
    btrl_pkg::res_t res;
    logic           res_valid;
    logic           res_ready;

    logic                                m_axis_tvalid_reg, m_axis_tvalid_next;
    logic [btrl_pkg::ROUTE_HOST_W-1:0]   route_host_reg;
    logic [btrl_pkg::STATUS_W-1:0]       status_reg;

    // Unpack the request word
    assign req.req_type  = s_axis_tuser;
    assign req.addr_high = s_axis_tdata[63:0];
    assign req.addr_low  = s_axis_tdata[127:64];
    assign req.bit_count = s_axis_tdata[135:128];
    assign req.host_id   = s_axis_tdata[151:136];

    btrl_engine #(
        .ADDR_BITS    (ADDR_BITS),
        .NODE_COUNT   (NODE_COUNT),
        .HOST_ID_BITS (HOST_ID_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_valid (s_axis_tvalid),
        .req_ready (s_axis_tready),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

    // Output register takes a result when empty or being drained
    assign res_ready = ~m_axis_tvalid_reg | m_axis_tready;

    always_comb
    begin
        m_axis_tvalid_next = m_axis_tvalid_reg;
        if (res_valid && res_ready)
        begin
            m_axis_tvalid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_axis_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_axis_tvalid_reg <= m_axis_tvalid_next;
        end
    end

    // Capture the result word
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            route_host_reg <= res.route_host;
            status_reg     <= res.status;
        end
    end

    assign m_axis_tvalid = m_axis_tvalid_reg;
    assign m_axis_tdata  = {1'b0, route_host_reg};
    assign m_axis_tuser  = status_reg;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int TRIE_NODES     = btrl_pkg::NODE_COUNT_DEF;
    localparam int WALK_BITS      = btrl_pkg::ADDR_BITS_DEF;
    localparam int BASE_COUNT     = 6;
    localparam int FILL_ADDS      = 45;
    localparam int RX_HOLD_CYCLES = 500;
    localparam int DRAIN_CYCLES   = 300;
    localparam int CYCLE_LIMIT    = 1000000;

    // Request code 3 has no meaning; the block answers it with a plain ok
    localparam logic [btrl_pkg::REQ_TYPE_W-1:0] REQ_NONE = 2'd3;

    localparam logic [15:0] HOST_DROP = 16'hFFFF;
    localparam logic [127:0] ADDR_ONES = '1;
    localparam logic [127:0] ADDR_ZERO = '0;
    localparam logic [127:0] ADDR_HI_ONES = {64'hFFFF_FFFF_FFFF_FFFF, 64'h0};
    localparam logic [127:0] ADDR_LO_ONES = {64'h0, 64'hFFFF_FFFF_FFFF_FFFF};
    localparam logic [127:0] ADDR_STRIPE = {64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555};

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata = '0;   // addr_high, addr_low, bit_count, host_id
    logic [1:0]   s_axis_tuser = '0;   // req_type
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [15:0]  m_axis_tdata;        // route_host, one zero pad bit
    logic [1:0]   m_axis_tuser;        // status

    // Predicted route table
    int unsigned trie_child [TRIE_NODES][2];
    bit          trie_has_route [TRIE_NODES];
    logic [15:0] trie_host [TRIE_NODES];
    int unsigned trie_used;

    btrl_pkg::req_t pending_reqs [$];
    btrl_pkg::res_t route_expect [$];
    btrl_pkg::req_t req_on_bus;
    logic [127:0] route_bases [BASE_COUNT];

    bit          req_taken = 1'b0;
    bit          no_stalls = 1'b0;
    bit          rx_hold_req = 1'b0;
    int          tx_gap = 0;
    int          rx_gap = 0;
    int          rx_hold_left = 0;
    int          bad_results = 0;
    int unsigned cycle_count = 0;

    binary_trie_route_lookup_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // Empty table: only the root, holding no route
    function automatic void trie_clear();
        trie_child[0][0] = 0;
        trie_child[0][1] = 0;
        trie_has_route[0] = 1'b0;
        trie_host[0] = '0;
        trie_used = 1;
    endfunction

    // Apply one request to the predicted table and return its result word
    function automatic btrl_pkg::res_t route_predict(btrl_pkg::req_t r);
        logic [127:0] addr;
        int unsigned  len;
        int unsigned  depth;
        int unsigned  cur;
        int unsigned  nn;
        bit           found;
        bit           dead_end;
        logic [15:0]  best;
        btrl_pkg::res_t res;
        addr = {r.addr_high, r.addr_low};
        len = (r.bit_count > WALK_BITS) ? WALK_BITS : r.bit_count;
        res.status = btrl_pkg::ST_OK;
        res.route_host = '0;
        cur = 0;
        depth = 0;
        found = 1'b0;
        dead_end = 1'b0;
        best = '0;
        case (r.req_type)
            btrl_pkg::REQ_ADD:
            begin
                // follow existing links as far as they go
                while (depth < len && trie_child[cur][addr[127 - depth]] != 0)
                begin
                    cur = trie_child[cur][addr[127 - depth]];
                    depth++;
                end
                if (len - depth > TRIE_NODES - trie_used)
                    res.status = btrl_pkg::ST_FULL;
                else
                begin
                    // allocate the missing tail of the path
                    while (depth < len)
                    begin
                        nn = trie_used;
                        trie_child[nn][0] = 0;
                        trie_child[nn][1] = 0;
                        trie_has_route[nn] = 1'b0;
                        trie_host[nn] = '0;
                        trie_child[cur][addr[127 - depth]] = nn;
                        trie_used++;
                        cur = nn;
                        depth++;
                    end
                    trie_has_route[cur] = !r.host_id[15];
                    trie_host[cur] = r.host_id[15] ? 16'h0 : r.host_id;
                end
            end
            btrl_pkg::REQ_LOOKUP:
            begin
                // remember the deepest route met along the path
                while (depth < len && !dead_end)
                begin
                    if (trie_has_route[cur])
                    begin
                        found = 1'b1;
                        best = trie_host[cur];
                    end
                    if (trie_child[cur][addr[127 - depth]] == 0)
                        dead_end = 1'b1;
                    else
                    begin
                        cur = trie_child[cur][addr[127 - depth]];
                        depth++;
                    end
                end
                if (trie_has_route[cur])
                begin
                    found = 1'b1;
                    best = trie_host[cur];
                end
                if (found)
                    res.route_host = best[14:0];
                else
                    res.status = btrl_pkg::ST_NOROUTE;
            end
            btrl_pkg::REQ_CLEAR:
                trie_clear();
            default:
                ;
        endcase
        return res;
    endfunction

    function automatic void queue_req(logic [1:0] kind, logic [127:0] addr,
                                      logic [7:0] len, logic [15:0] host);
        btrl_pkg::req_t r;
        r.req_type  = kind;
        r.addr_high = addr[127:64];
        r.addr_low  = addr[63:0];
        r.bit_count = len;
        r.host_id   = host;
        pending_reqs.push_back(r);
    endfunction

    function automatic logic [127:0] rand_addr();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Prefix lengths: mostly in range, some full, some past the address width
    function automatic logic [7:0] rand_len();
        case ($urandom_range(0, 9))
            0, 1:    return 8'($urandom_range(0, 16));
            2, 3, 4, 5: return 8'($urandom_range(17, 127));
            6, 7:    return 8'd128;
            8:       return 8'($urandom_range(129, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Host ids: mostly valid, some removals by -1 and by other negatives
    function automatic logic [15:0] rand_host();
        case ($urandom_range(0, 9))
            0:       return HOST_DROP;
            1:       return {1'b1, 15'($urandom)};
            default: return 16'($urandom_range(0, 32767));
        endcase
    endfunction

    // Related base addresses, so routes nest and lookups hit them
    function automatic void refresh_bases();
        route_bases[0] = rand_addr();
        for (int k = 1; k < BASE_COUNT; k++)
            route_bases[k] = route_bases[0] ^ (rand_addr() >> $urandom_range(0, 127));
    endfunction

    // Base address with its top keep bits intact and the rest scrambled
    function automatic logic [127:0] near_addr(int unsigned keep);
        return route_bases[$urandom_range(0, BASE_COUNT - 1)] ^ (rand_addr() >> keep);
    endfunction

    function automatic void queue_mix(int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                refresh_bases();
            pick = $urandom_range(0, 99);
            if (pick < 38)
                queue_req(btrl_pkg::REQ_ADD,
                          near_addr($urandom_range(0, 3) != 0 ? 128 : $urandom_range(0, 127)),
                          rand_len(), rand_host());
            else if (pick < 92)
                queue_req(btrl_pkg::REQ_LOOKUP, near_addr($urandom_range(0, 128)), rand_len(),
                          16'($urandom_range(0, 65535)));
            else if (pick < 94)
                queue_req(btrl_pkg::REQ_CLEAR, rand_addr(), 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)));
            else if (pick < 96)
                queue_req(REQ_NONE, rand_addr(), 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)));
            else
                queue_req(2'($urandom_range(0, 1)), rand_addr(), 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)));
        end
    endfunction

    // Wait until every request is taken and every result is back
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_axis_tvalid || route_expect.size() != 0)
            @(negedge clk);
    endtask

    // Request driver: advance to the next word once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n && (req_taken || !s_axis_tvalid))
        begin
            req_taken = 1'b0;
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() != 0 && !no_stalls && $urandom_range(0, 7) == 0)
            begin
                tx_gap = $urandom_range(0, 17);
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                req_on_bus = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {req_on_bus.host_id, req_on_bus.bit_count,
                                 req_on_bus.addr_low, req_on_bus.addr_high};
                s_axis_tuser <= req_on_bus.req_type;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                rx_hold_left = RX_HOLD_CYCLES;
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (!no_stalls && $urandom_range(0, 9) == 0)
            begin
                rx_gap = $urandom_range(0, 17);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Predict on each taken request, check each result word in order
    always @(posedge clk)
    begin
        btrl_pkg::res_t want;
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("tb: done, errors");
                $finish;
            end
            else
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    route_expect.push_back(route_predict(req_on_bus));
                    req_taken = 1'b1;
                end
                if (m_axis_tvalid && m_axis_tready)
                begin
                    if (route_expect.size() == 0)
                    begin
                        $display("%0t: unexpected result: status %0d host %0d",
                                 $time, m_axis_tuser, m_axis_tdata[14:0]);
                        bad_results++;
                    end
                    else
                    begin
                        want = route_expect.pop_front();
                        if (m_axis_tuser !== want.status
                            || m_axis_tdata[14:0] !== want.route_host)
                        begin
                            $display("%0t: mismatch: expected status %0d host %0d, got status %0d host %0d",
                                     $time, want.status, want.route_host,
                                     m_axis_tuser, m_axis_tdata[14:0]);
                            bad_results++;
                        end
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [127:0] fill_addr [FILL_ADDS];
        trie_clear();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, root route, extremes, removals, odd codes
        queue_req(btrl_pkg::REQ_LOOKUP, ADDR_ONES, 8'd128, 16'h0);
        queue_req(btrl_pkg::REQ_LOOKUP, ADDR_ZERO, 8'd0, 16'h0);
        queue_req(btrl_pkg::REQ_ADD, ADDR_ZERO, 8'd0, 16'd5);
        queue_req(btrl_pkg::REQ_LOOKUP, ADDR_ONES, 8'd0, 16'h0);
        queue_req(btrl_pkg::REQ_ADD, ADDR_ONES, 8'd128, 16'h7FFF);
        queue_req(btrl_pkg::REQ_LOOKUP, ADDR_ONES, 8'd128, 16'h0);
        queue_req(btrl_pkg::REQ_LOOKUP, ADDR_ONES, 8'd255, 16'hFFFF);
        queue_req(btrl_pkg::REQ_ADD, ADDR_ZERO, 8'd200, 16'h0);
        queue_req(btrl_pkg::REQ_LOOKUP, ADDR_ZERO, 8'd128, 16'h0);
        queue_req(btrl_pkg::REQ_LOOKUP, ADDR_LO_ONES, 8'd128, 16'h0);
        queue_req(btrl_pkg::REQ_ADD, ADDR_ONES, 8'd64, 16'd100);
        queue_req(btrl_pkg::REQ_LOOKUP, ADDR_HI_ONES, 8'd128, 16'h0);
        queue_req(btrl_pkg::REQ_ADD, ADDR_ONES, 8'd128, HOST_DROP);
        queue_req(btrl_pkg::REQ_LOOKUP, ADDR_ONES, 8'd128, 16'h0);
        queue_req(btrl_pkg::REQ_ADD, ADDR_ONES, 8'd64, 16'h8000);
        queue_req(btrl_pkg::REQ_LOOKUP, ADDR_ONES, 8'd128, 16'h0);
        queue_req(btrl_pkg::REQ_ADD, ADDR_STRIPE, 8'd20, HOST_DROP);
        queue_req(btrl_pkg::REQ_LOOKUP, ADDR_STRIPE, 8'd20, 16'h0);
        queue_req(REQ_NONE, ADDR_ONES, 8'd255, 16'hFFFF);
        queue_req(btrl_pkg::REQ_CLEAR, ADDR_ZERO, 8'd0, 16'h0);
        queue_req(btrl_pkg::REQ_LOOKUP, ADDR_ONES, 8'd128, 16'h0);
        queue_req(btrl_pkg::REQ_ADD, ADDR_ONES, 8'd1, 16'h2AAA);
        queue_req(btrl_pkg::REQ_LOOKUP, ADDR_ONES, 8'd1, 16'h0);
        wait_drained();

        // Random traffic around related prefixes
        queue_mix(330);
        wait_drained();

        // Exhaust the node pool with full-length routes, then probe it
        queue_req(btrl_pkg::REQ_CLEAR, ADDR_ZERO, 8'd0, 16'h0);
        for (int i = 0; i < FILL_ADDS; i++)
        begin
            fill_addr[i] = rand_addr();
            queue_req(btrl_pkg::REQ_ADD, fill_addr[i], 8'd128, 16'($urandom_range(0, 32767)));
            if (i % 4 == 3)
                queue_req(btrl_pkg::REQ_LOOKUP, fill_addr[i - 2], 8'd128, 16'h0);
        end
        queue_req(btrl_pkg::REQ_ADD, rand_addr(), 8'd128, HOST_DROP);
        queue_req(btrl_pkg::REQ_ADD, fill_addr[0], 8'd100, 16'd7);
        queue_req(btrl_pkg::REQ_LOOKUP, fill_addr[0], 8'd100, 16'h0);
        queue_req(btrl_pkg::REQ_LOOKUP, fill_addr[FILL_ADDS - 1], 8'd128, 16'h0);
        queue_req(btrl_pkg::REQ_ADD, fill_addr[3], 8'd128, HOST_DROP);
        queue_req(btrl_pkg::REQ_LOOKUP, fill_addr[3], 8'd128, 16'h0);
        queue_req(btrl_pkg::REQ_CLEAR, ADDR_ZERO, 8'd0, 16'h0);
        wait_drained();

        // Long receiver hold-off while short requests keep coming
        rx_hold_req = 1'b1;
        refresh_bases();
        for (int i = 0; i < 30; i++)
        begin
            if (i % 3 == 0)
                queue_req(btrl_pkg::REQ_ADD, near_addr(128), 8'($urandom_range(0, 8)),
                          rand_host());
            else
                queue_req(btrl_pkg::REQ_LOOKUP, near_addr(128), 8'($urandom_range(0, 8)),
                          16'($urandom_range(0, 65535)));
        end
        // hold the sender until every result is back
        wait_drained();

        // Final stretch at full rate on both sides
        no_stalls = 1'b1;
        queue_mix(120);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (bad_results == 0 && route_expect.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
sv/btrl_pkg.sv
sv/btrl_engine.sv
sv/binary_trie_route_lookup_top.sv
tb/tb.sv
